>>> hw/rtl/skm_pkg.sv
package skm_pkg;

    // Field and register widths, fixed by the interface.
    localparam int SAMPLE_W = 32;
    localparam int NOISE_W  = 24;
    localparam int THR_W    = 31;
    localparam int COV_W    = 32;
    localparam int MAG_W    = 33;
    localparam int PP_W     = 33;
    localparam int DEN_W    = 34;
    localparam int CORR_W   = 34;
    localparam int SUM_W    = 36;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE  = 2'd0,
        REG_MEASURE_NOISE  = 2'd1,
        REG_JUMP_THRESHOLD = 2'd2,
        REG_COV_RESTART    = 2'd3
    } cfg_reg_t;

    localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST  = 24'd655;
    localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST  = 24'd32768;
    localparam logic [THR_W-1:0]   JUMP_THRESHOLD_RST = 31'd1310720;
    localparam logic [NOISE_W-1:0] COV_RESTART_RST    = 24'd65536;

    localparam logic signed [SUM_W-1:0] EST_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] EST_MIN = 36'shF_8000_0000;

    // Control from the sequencer to the divider and the accumulators.
    typedef struct packed {
        logic start;
        logic step;
    } skm_ctl_t;

    // One quotient bit as it leaves the divider.
    typedef struct packed {
        logic q_bit;
        logic q_valid;
    } skm_qbit_t;

endpackage

>>> hw/rtl/scalar_kalman_smoother.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    sample
// output    out        out_valid / out_ready  estimate, snapped
// config    in         cfg_we (no wait)       cfg_index, cfg_data
//
// A filter step runs from the accepting beat through the PREP, ABS, DIV,
// TAIL, FIN and DONE states to the result register; the DIV state runs the
// bit-serial gain divider, which yields one quotient bit per cycle. A snap
// goes from ABS straight to DONE. A new beat is taken only in the idle
// state, which lies between one step and the next.
// One sample is in work at a time; a new beat is taken once the previous
// result is in the output register, even while that result still waits.
// A stalled output holds the finished step in its last state until the
// output register is free. Reset loads the register defaults, a zero
// estimate and a covariance of 1.0.
module scalar_kalman_smoother #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [skm_pkg::SAMPLE_W-1:0] sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [skm_pkg::SAMPLE_W-1:0] estimate,
    output logic                               snapped,
    input  logic                               cfg_we,
    input  logic [skm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [skm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import skm_pkg::*;

    localparam int ACC_W = FRAC_BITS + MAG_W + 1;
    localparam int PT_W  = FRAC_BITS + PP_W;
    localparam int PS_W  = PT_W + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    localparam logic [COV_W-1:0] COV_ONE   = COV_W'(1) << FRAC_BITS;
    localparam logic [ACC_W:0]   HALF_ACC  = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [PS_W-1:0]  HALF_PT   = PS_W'(1) << (FRAC_BITS - 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PREP = 7'b0000010,
        ST_ABS  = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_TAIL = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic [NOISE_W-1:0] q_noise_reg;
    logic [NOISE_W-1:0] r_noise_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [NOISE_W-1:0] cov_restart_reg;

    // Filter state.
    logic signed [SAMPLE_W-1:0] est_reg;
    logic [COV_W-1:0]           cov_reg;

    // Per-sample working registers.
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [MAG_W-1:0]           diff_reg;
    logic [PP_W-1:0]            pp_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic                       neg_reg;
    logic                       snap_reg;
    logic [CORR_W-1:0]          corr_reg;
    logic [PT_W-1:0]            ptmp_reg;
    logic [CNT_W-1:0]           cnt_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] estimate_reg;
    logic                       snapped_reg;

    skm_ctl_t   ctl;
    skm_qbit_t  q;
    logic [ACC_W-1:0] acc_mag;
    logic [ACC_W-1:0] acc_pp;

    logic [MAG_W-1:0]           mag_c;
    logic                       est_pos;
    logic [DEN_W-1:0]           den_c;
    logic [ACC_W:0]             corr_sum;
    logic [PS_W-1:0]            p_sum;
    logic [CORR_W-1:0]          p_round;
    logic [COV_W-1:0]           cov_new;
    logic signed [SUM_W-1:0]    est_sum;
    logic signed [SAMPLE_W-1:0] est_new;
    logic                       slot_free;

    always_comb
    begin
        // Magnitude of the innovation and the gain denominator.
        mag_c   = diff_reg[MAG_W-1] ? (~diff_reg + MAG_W'(1)) : diff_reg;
        est_pos = !est_reg[SAMPLE_W-1] && (est_reg != '0);
        den_c   = {1'b0, pp_reg} + DEN_W'(r_noise_reg);

        // Round the correction and the new covariance to nearest.
        corr_sum = {1'b0, acc_mag} + HALF_ACC;
        p_sum    = {1'b0, ptmp_reg} + HALF_PT;
        p_round  = p_sum[FRAC_BITS +: CORR_W];
        cov_new  = (p_round[CORR_W-1:COV_W] != '0) ? '1 : p_round[COV_W-1:0];

        est_sum = neg_reg ? (SUM_W'(est_reg) - $signed({2'b00, corr_reg}))
                          : (SUM_W'(est_reg) + $signed({2'b00, corr_reg}));
        if (est_sum > EST_MAX)
        begin
            est_new = EST_MAX[SAMPLE_W-1:0];
        end
        else if (est_sum < EST_MIN)
        begin
            est_new = EST_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            est_new = est_sum[SAMPLE_W-1:0];
        end

        slot_free = !out_valid_reg || out_ready;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        ctl.start  = 1'b0;
        ctl.step   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                ctl.start = 1'b1;
                if (est_pos && (mag_c > MAG_W'(thr_reg)))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                ctl.step = 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            q_noise_reg     <= PROCESS_NOISE_RST;
            r_noise_reg     <= MEASURE_NOISE_RST;
            thr_reg         <= JUMP_THRESHOLD_RST;
            cov_restart_reg <= COV_RESTART_RST;
            est_reg         <= '0;
            cov_reg         <= COV_ONE;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PROCESS_NOISE:  q_noise_reg     <= cfg_data[NOISE_W-1:0];
                    REG_MEASURE_NOISE:  r_noise_reg     <= cfg_data[NOISE_W-1:0];
                    REG_JUMP_THRESHOLD: thr_reg         <= cfg_data[THR_W-1:0];
                    REG_COV_RESTART:    cov_restart_reg <= cfg_data[NOISE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_ABS)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (state_reg == ST_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
                est_reg       <= snap_reg ? x_reg : est_new;
                cov_reg       <= snap_reg ? COV_W'(cov_restart_reg) : cov_new;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            x_reg <= sample;
        end
        if (state_reg == ST_PREP)
        begin
            diff_reg <= {x_reg[SAMPLE_W-1], x_reg} - {est_reg[SAMPLE_W-1], est_reg};
            pp_reg   <= PP_W'(cov_reg) + PP_W'(q_noise_reg);
        end
        if (state_reg == ST_ABS)
        begin
            mag_reg  <= mag_c;
            neg_reg  <= diff_reg[MAG_W-1];
            snap_reg <= est_pos && (mag_c > MAG_W'(thr_reg));
        end
        if (state_reg == ST_FIN)
        begin
            corr_reg <= corr_sum[FRAC_BITS +: CORR_W];
            ptmp_reg <= {pp_reg, {FRAC_BITS{1'b0}}} - acc_pp[PT_W-1:0];
        end
        if (state_reg == ST_DONE && slot_free)
        begin
            estimate_reg <= snap_reg ? x_reg : est_new;
            snapped_reg  <= snap_reg;
        end
    end

    skm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .pp    (pp_reg),
        .den   (den_c),
        .q     (q)
    );

    skm_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk     (clk),
        .ctl     (ctl),
        .q       (q),
        .mag     (mag_reg),
        .pp      (pp_reg),
        .acc_mag (acc_mag),
        .acc_pp  (acc_pp)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign estimate  = estimate_reg;
    assign snapped   = snapped_reg;

    // The last quotient bit must reach the accumulators in the tail cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAIL) |-> q.q_valid)
    else $error("quotient bit missing in tail cycle");

    // The bit counter never runs past the last quotient bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(FRAC_BITS)))
    else $error("divider bit counter overrun");

    // The filter state changes only when a step completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DONE) |=> ($stable(cov_reg) && $stable(est_reg)))
    else $error("filter state changed outside completion");

endmodule

>>> hw/rtl/skm_div.sv
module skm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  skm_pkg::skm_ctl_t          ctl,
    input  logic [skm_pkg::PP_W-1:0]   pp,
    input  logic [skm_pkg::DEN_W-1:0]  den,
    output skm_pkg::skm_qbit_t         q
);
    import skm_pkg::*;

    localparam int REM_W = DEN_W + 1;

    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [REM_W-1:0] rem_sub;
    logic [REM_W-1:0] rem_keep;
    logic [DEN_W-1:0] den_reg;
    logic             q_bit_reg;
    logic             q_bit_next;
    logic             q_valid_reg;

    // Restoring division, one quotient bit per step, most significant first.
    // A zero divisor gives a zero quotient.
    always_comb
    begin
        rem_sub    = rem_reg - {1'b0, den_reg};
        q_bit_next = (rem_reg >= {1'b0, den_reg}) && (den_reg != '0);
        rem_keep   = q_bit_next ? rem_sub : rem_reg;
        rem_next   = {rem_keep[REM_W-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= {2'b00, pp};
            den_reg <= den;
        end
        else if (ctl.step)
        begin
            rem_reg <= rem_next;
        end
        if (ctl.step)
        begin
            q_bit_reg <= q_bit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= ctl.step;
        end
    end

    assign q.q_bit   = q_bit_reg;
    assign q.q_valid = q_valid_reg;

endmodule

>>> hw/rtl/skm_mac.sv
module skm_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                     clk,
    input  skm_pkg::skm_ctl_t                        ctl,
    input  skm_pkg::skm_qbit_t                       q,
    input  logic [skm_pkg::MAG_W-1:0]                mag,
    input  logic [skm_pkg::PP_W-1:0]                 pp,
    output logic [FRAC_BITS+skm_pkg::MAG_W:0]        acc_mag,
    output logic [FRAC_BITS+skm_pkg::MAG_W:0]        acc_pp
);
    import skm_pkg::*;

    localparam int ACC_W = FRAC_BITS + MAG_W + 1;

    logic [ACC_W-1:0] acc_mag_reg;
    logic [ACC_W-1:0] acc_pp_reg;
    logic [ACC_W-1:0] acc_mag_next;
    logic [ACC_W-1:0] acc_pp_next;

    // Horner form: shift the sum left and add the operand for each gain bit.
    always_comb
    begin
        acc_mag_next = {acc_mag_reg[ACC_W-2:0], 1'b0} + (q.q_bit ? ACC_W'(mag) : '0);
        acc_pp_next  = {acc_pp_reg[ACC_W-2:0], 1'b0} + (q.q_bit ? ACC_W'(pp) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_mag_reg <= '0;
            acc_pp_reg  <= '0;
        end
        else if (q.q_valid)
        begin
            acc_mag_reg <= acc_mag_next;
            acc_pp_reg  <= acc_pp_next;
        end
    end

    assign acc_mag = acc_mag_reg;
    assign acc_pp  = acc_pp_reg;

endmodule
